// File: rtl/nts_pkg.sv
// ----------------------------------------------------------------------------
// nts_pkg
// Shared constants, types and helpers of the nearest thumbnail downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package nts_pkg;

    localparam int MAX_THUMB_WIDTH = 160;
    localparam int SRC_MAX         = 4096;

    localparam int DIM_W   = 13;     // source width or height, 1..4096
    localparam int POS_W   = 12;     // source column or row, 0..4095
    localparam int TW_W    = 8;      // thumbnail width and column
    localparam int TH_W    = 13;     // thumbnail height and row
    localparam int COLOR_W = 8;

    localparam int DIV_N_W     = 20;  // widest dividend: height times thumbnail width
    localparam int DIV_D_W     = 13;
    localparam int DIV_STEPS   = DIV_N_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT = 1'd1;

    localparam logic [DIM_W-1:0]   SOURCE_WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0]   SOURCE_HEIGHT_RESET = 13'd480;
    localparam logic [COLOR_W-1:0] ALPHA_FULL          = 8'hFF;

    typedef enum logic [1:0] {
        DIV_TH,
        DIV_COL,
        DIV_ROW
    } div_sel_t;

    typedef struct packed {
        logic     latch_dims;
        logic     div_start;
        div_sel_t div_sel;
        logic     take_pixel;
    } nts_cmd_t;

    typedef struct packed {
        logic at_origin;
        logic div_done;
        logic out_free;
    } nts_sts_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(SRC_MAX))
            r = DIM_W'(SRC_MAX);
        else
            r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/nts_if.sv
// ----------------------------------------------------------------------------
// nts_if
// Request channels of the downscaler: source pixels, thumbnail pixels and
// register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface nts_pix_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;

    modport source (output valid, output blue, output green, output red, input ready);
    modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface nts_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
    logic       row_end;
    logic       frame_end;

    modport source (output valid, output out_blue, output out_green, output out_red,
                    output out_alpha, output row_end, output frame_end, input ready);
    modport sink   (input valid, input out_blue, input out_green, input out_red,
                    input out_alpha, input row_end, input frame_end, output ready);
endinterface

interface nts_cfg_if
    import nts_pkg::*;
    ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/nts_div.sv
// ----------------------------------------------------------------------------
// nts_div
// Restoring divider, one quotient bit per cycle, used for the frame setup.
// ----------------------------------------------------------------------------
`default_nettype none

module nts_div
    import nts_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [DIV_N_W-1:0] dividend,
    input  wire logic [DIV_D_W-1:0] divisor,
    output logic                    done,
    output logic [DIV_N_W-1:0]      quotient,
    output logic [DIV_D_W-1:0]      remainder
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_D_W-1:0]   dsr_reg, dsr_next;

    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W:0]     trial;

    assign shifted = {rem_reg, quo_reg[DIV_N_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = trial[DIV_D_W-1:0];
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIV_D_W-1:0];
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// File: rtl/nts_dp.sv
// ----------------------------------------------------------------------------
// nts_dp
// Datapath: registers, frame geometry, position counters, pick steppers and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nts_dp
    import nts_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire nts_cmd_t               cmd,
    output nts_sts_t                    sts,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [COLOR_W-1:0]     blue,
    input  wire logic [COLOR_W-1:0]     green,
    input  wire logic [COLOR_W-1:0]     red,
    input  wire logic                   out_ready,
    output logic                        out_valid,
    output logic [COLOR_W-1:0]          out_blue,
    output logic [COLOR_W-1:0]          out_green,
    output logic [COLOR_W-1:0]          out_red,
    output logic [COLOR_W-1:0]          out_alpha,
    output logic                        row_end,
    output logic                        frame_end
);

    // registers and frame geometry
    logic [DIM_W-1:0] cfg_w_reg, cfg_w_next;
    logic [DIM_W-1:0] cfg_h_reg, cfg_h_next;
    logic [DIM_W-1:0] w_reg, w_next;
    logic [DIM_W-1:0] h_reg, h_next;
    logic [TW_W-1:0]  tw_reg, tw_next;
    logic [TH_W-1:0]  th_reg, th_next;
    logic [DIM_W-1:0] col_step_q_reg, col_step_q_next;
    logic [TW_W-1:0]  col_step_r_reg, col_step_r_next;
    logic [DIM_W-1:0] row_step_q_reg, row_step_q_next;
    logic [TH_W-1:0]  row_step_r_reg, row_step_r_next;
    div_sel_t         div_sel_reg, div_sel_next;

    // positions
    logic [POS_W-1:0] scol_reg, scol_next;
    logic [POS_W-1:0] srow_reg, srow_next;
    logic [TW_W-1:0]  tcol_reg, tcol_next;
    logic [TH_W-1:0]  trow_reg, trow_next;
    logic [DIM_W-1:0] col_q_reg, col_q_next;
    logic [TW_W-1:0]  col_r_reg, col_r_next;
    logic [DIM_W-1:0] row_q_reg, row_q_next;
    logic [TH_W-1:0]  row_r_reg, row_r_next;

    // output register
    logic               ov_reg, ov_next;
    logic [COLOR_W-1:0] ob_reg, ob_next;
    logic [COLOR_W-1:0] og_reg, og_next;
    logic [COLOR_W-1:0] or_reg, or_next;
    logic               ore_reg, ore_next;
    logic               ofe_reg, ofe_next;

    // divider
    logic [DIV_N_W-1:0] div_n;
    logic [DIV_D_W-1:0] div_d;
    logic               div_done;
    logic [DIV_N_W-1:0] div_q;
    logic [DIV_D_W-1:0] div_r;
    logic [DIM_W+TW_W-1:0] th_prod;

    // step logic
    logic [DIM_W-1:0] w_clamp;
    logic [DIM_W-1:0] h_clamp;
    logic             row_picked;
    logic             pick;
    logic             re;
    logic             fe;
    logic [DIM_W-1:0] scol_sum;
    logic [DIM_W-1:0] srow_sum;
    logic [TW_W:0]    col_r_sum;
    logic [TH_W:0]    row_r_sum;
    logic             row_wrap;

    nts_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_n),
        .divisor   (div_d),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign th_prod = (DIM_W+TW_W)'(h_reg) * (DIM_W+TW_W)'(tw_reg);

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_TH:
            begin
                div_n = th_prod[DIV_N_W-1:0];
                div_d = w_reg;
            end
            DIV_COL:
            begin
                div_n = DIV_N_W'(w_reg);
                div_d = DIV_D_W'(tw_reg);
            end
            DIV_ROW:
            begin
                div_n = DIV_N_W'(h_reg);
                div_d = DIV_D_W'(th_reg);
            end
            default:
            begin
                div_n = '0;
                div_d = '0;
            end
        endcase
    end

    assign w_clamp = clamp_dim(cfg_w_reg);
    assign h_clamp = clamp_dim(cfg_h_reg);

    assign row_picked = ({1'b0, srow_reg} == row_q_reg) && (trow_reg < th_reg);
    assign pick       = row_picked && (tcol_reg < tw_reg) && ({1'b0, scol_reg} == col_q_reg);
    assign re         = (tcol_reg + 1'b1) == tw_reg;
    assign fe         = re && ((trow_reg + 1'b1) == th_reg);

    assign scol_sum  = {1'b0, scol_reg} + 1'b1;
    assign srow_sum  = {1'b0, srow_reg} + 1'b1;
    assign row_wrap  = scol_sum >= w_reg;
    assign col_r_sum = {1'b0, col_r_reg} + {1'b0, col_step_r_reg};
    assign row_r_sum = {1'b0, row_r_reg} + {1'b0, row_step_r_reg};

    always_comb
    begin
        cfg_w_next      = cfg_w_reg;
        cfg_h_next      = cfg_h_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        tw_next         = tw_reg;
        th_next         = th_reg;
        col_step_q_next = col_step_q_reg;
        col_step_r_next = col_step_r_reg;
        row_step_q_next = row_step_q_reg;
        row_step_r_next = row_step_r_reg;
        div_sel_next    = div_sel_reg;
        scol_next       = scol_reg;
        srow_next       = srow_reg;
        tcol_next       = tcol_reg;
        trow_next       = trow_reg;
        col_q_next      = col_q_reg;
        col_r_next      = col_r_reg;
        row_q_next      = row_q_reg;
        row_r_next      = row_r_reg;
        ov_next         = ov_reg;
        ob_next         = ob_reg;
        og_next         = og_reg;
        or_next         = or_reg;
        ore_next        = ore_reg;
        ofe_next        = ofe_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SOURCE_WIDTH:  cfg_w_next = cfg_data;
                CFG_SOURCE_HEIGHT: cfg_h_next = cfg_data;
                default:           ;
            endcase
        end

        // frame start
        if (cmd.latch_dims)
        begin
            w_next = w_clamp;
            h_next = h_clamp;
            if (w_clamp < DIM_W'(MAX_THUMB_WIDTH))
                tw_next = w_clamp[TW_W-1:0];
            else
                tw_next = TW_W'(MAX_THUMB_WIDTH);
            tcol_next  = '0;
            trow_next  = '0;
            col_q_next = '0;
            col_r_next = '0;
            row_q_next = '0;
            row_r_next = '0;
        end

        if (cmd.div_start)
            div_sel_next = cmd.div_sel;

        if (div_done)
        begin
            unique case (div_sel_reg)
                DIV_TH:
                begin
                    if (div_q == '0)
                        th_next = TH_W'(1);
                    else
                        th_next = div_q[TH_W-1:0];
                end
                DIV_COL:
                begin
                    col_step_q_next = div_q[DIM_W-1:0];
                    col_step_r_next = div_r[TW_W-1:0];
                end
                DIV_ROW:
                begin
                    row_step_q_next = div_q[DIM_W-1:0];
                    row_step_r_next = div_r[TH_W-1:0];
                end
                default: ;
            endcase
        end

        if (out_ready)
            ov_next = 1'b0;

        if (cmd.take_pixel)
        begin
            if (pick)
            begin
                ov_next   = 1'b1;
                ob_next   = blue;
                og_next   = green;
                or_next   = red;
                ore_next  = re;
                ofe_next  = fe;
                tcol_next = tcol_reg + 1'b1;
                if (col_r_sum >= {1'b0, tw_reg})
                begin
                    col_r_next = TW_W'(col_r_sum - {1'b0, tw_reg});
                    col_q_next = col_q_reg + col_step_q_reg + 1'b1;
                end
                else
                begin
                    col_r_next = col_r_sum[TW_W-1:0];
                    col_q_next = col_q_reg + col_step_q_reg;
                end
            end

            if (row_wrap)
            begin
                scol_next = '0;
                if (row_picked)
                begin
                    trow_next  = trow_reg + 1'b1;
                    tcol_next  = '0;
                    col_q_next = '0;
                    col_r_next = '0;
                    if (row_r_sum >= {1'b0, th_reg})
                    begin
                        row_r_next = TH_W'(row_r_sum - {1'b0, th_reg});
                        row_q_next = row_q_reg + row_step_q_reg + 1'b1;
                    end
                    else
                    begin
                        row_r_next = row_r_sum[TH_W-1:0];
                        row_q_next = row_q_reg + row_step_q_reg;
                    end
                end
                if (srow_sum >= h_reg)
                    srow_next = '0;
                else
                    srow_next = srow_sum[POS_W-1:0];
            end
            else
            begin
                scol_next = scol_sum[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg   <= SOURCE_WIDTH_RESET;
            cfg_h_reg   <= SOURCE_HEIGHT_RESET;
            w_reg       <= '0;
            h_reg       <= '0;
            tw_reg      <= '0;
            th_reg      <= '0;
            div_sel_reg <= DIV_TH;
            scol_reg    <= '0;
            srow_reg    <= '0;
            tcol_reg    <= '0;
            trow_reg    <= '0;
            col_q_reg   <= '0;
            col_r_reg   <= '0;
            row_q_reg   <= '0;
            row_r_reg   <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            cfg_w_reg   <= cfg_w_next;
            cfg_h_reg   <= cfg_h_next;
            w_reg       <= w_next;
            h_reg       <= h_next;
            tw_reg      <= tw_next;
            th_reg      <= th_next;
            div_sel_reg <= div_sel_next;
            scol_reg    <= scol_next;
            srow_reg    <= srow_next;
            tcol_reg    <= tcol_next;
            trow_reg    <= trow_next;
            col_q_reg   <= col_q_next;
            col_r_reg   <= col_r_next;
            row_q_reg   <= row_q_next;
            row_r_reg   <= row_r_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_step_q_reg <= col_step_q_next;
        col_step_r_reg <= col_step_r_next;
        row_step_q_reg <= row_step_q_next;
        row_step_r_reg <= row_step_r_next;
        ob_reg         <= ob_next;
        og_reg         <= og_next;
        or_reg         <= or_next;
        ore_reg        <= ore_next;
        ofe_reg        <= ofe_next;
    end

    assign sts.at_origin = (scol_reg == '0) && (srow_reg == '0);
    assign sts.div_done  = div_done;
    assign sts.out_free  = !ov_reg || out_ready;

    assign out_valid = ov_reg;
    assign out_blue  = ob_reg;
    assign out_green = og_reg;
    assign out_red   = or_reg;
    assign out_alpha = ALPHA_FULL;
    assign row_end   = ore_reg;
    assign frame_end = ofe_reg;

endmodule

`default_nettype wire

// File: rtl/nts_ctrl.sv
// ----------------------------------------------------------------------------
// nts_ctrl
// Controller: frame setup sequence and input acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module nts_ctrl
    import nts_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire nts_sts_t sts,
    input  wire logic     in_valid,
    output logic          in_ready,
    output nts_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_RUN,
        ST_DIV_TH,
        ST_WAIT_TH,
        ST_DIV_COL,
        ST_WAIT_COL,
        ST_DIV_ROW,
        ST_WAIT_ROW
    } state_t;

    state_t state_reg, state_next;
    logic   armed_reg, armed_next;
    logic   setup_needed;

    assign setup_needed = sts.at_origin && !armed_reg;
    assign in_ready     = (state_reg == ST_RUN) && sts.out_free && !setup_needed;

    always_comb
    begin
        state_next     = state_reg;
        armed_next     = armed_reg;
        cmd.latch_dims = 1'b0;
        cmd.div_start  = 1'b0;
        cmd.div_sel    = DIV_TH;
        cmd.take_pixel = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.take_pixel = 1'b1;
                    armed_next     = 1'b0;
                end
                else if (in_valid && setup_needed)
                begin
                    cmd.latch_dims = 1'b1;
                    state_next     = ST_DIV_TH;
                end
            end
            ST_DIV_TH:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_TH;
                state_next    = ST_WAIT_TH;
            end
            ST_WAIT_TH:
            begin
                if (sts.div_done)
                    state_next = ST_DIV_COL;
            end
            ST_DIV_COL:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_COL;
                state_next    = ST_WAIT_COL;
            end
            ST_WAIT_COL:
            begin
                if (sts.div_done)
                    state_next = ST_DIV_ROW;
            end
            ST_DIV_ROW:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_ROW;
                state_next    = ST_WAIT_ROW;
            end
            ST_WAIT_ROW:
            begin
                if (sts.div_done)
                begin
                    armed_next = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            armed_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            armed_reg <= armed_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/nearest_thumbnail_downscaler.sv
// ----------------------------------------------------------------------------
// nearest_thumbnail_downscaler
// Nearest neighbour thumbnail scaler for a raster pixel stream.
// ----------------------------------------------------------------------------
// pix_in carries source pixels (blue, green, red) in raster order; pix_out
// carries the kept pixels with alpha 255 and row_end / frame_end marks.
// cfg writes source_width (index 0) and source_height (index 1); it is always
// ready and takes effect at the next frame start.
// a frame starts whenever a request arrives at source position (0,0). the
// request is then held while a setup sequence runs the shared restoring
// divider three times (thumbnail height, column step, row step) after a
// step that latches the dimensions; each run starts the divider and waits
// for its done. after setup one source pixel is taken per cycle while
// pix_out is free; a kept pixel appears on pix_out in the cycle after it
// is taken, dropped pixels give nothing.
// pix_out is a single output register: when the receiver stalls with a
// result pending, pix_in stops taking requests until it is read.
// reset clears all positions, sets the registers to 640 by 480 and leaves
// the first pixel to start a new frame.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_thumbnail_downscaler
    import nts_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    nts_pix_in_if.sink    pix_in,
    nts_pix_out_if.source pix_out,
    nts_cfg_if.sink       cfg
);

    nts_cmd_t cmd;
    nts_sts_t sts;
    logic     in_ready;

    assign pix_in.ready = in_ready;
    assign cfg.ready    = 1'b1;

    nts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .sts      (sts),
        .in_valid (pix_in.valid),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    nts_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .blue      (pix_in.blue),
        .green     (pix_in.green),
        .red       (pix_in.red),
        .out_ready (pix_out.ready),
        .out_valid (pix_out.valid),
        .out_blue  (pix_out.out_blue),
        .out_green (pix_out.out_green),
        .out_red   (pix_out.out_red),
        .out_alpha (pix_out.out_alpha),
        .row_end   (pix_out.row_end),
        .frame_end (pix_out.frame_end)
    );

endmodule

`default_nettype wire
